### rtl/clpw_pkg.sv
// shared types and constants for the clamped line pixel walker
package clpw_pkg;

    localparam int CFG_BITS   = 13;
    localparam int PIX_X_BITS = 15;
    localparam int PIX_Y_BITS = 12;
    localparam int COUNT_BITS = 13;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } func_t;

    typedef struct packed {
        logic                  point_valid;
        logic [PIX_X_BITS-1:0] pixel_x;
        logic [PIX_Y_BITS-1:0] pixel_y;
        logic                  last_point;
        logic [COUNT_BITS-1:0] point_count;
    } result_t;

endpackage

### rtl/clpw_seg_if.sv
// segment command channel: function code and two endpoints
interface clpw_seg_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (
        output valid, func, start_x, start_y, end_x, end_y,
        input  ready
    );

    modport sink (
        input  valid, func, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

### rtl/clpw_pix_if.sv
// pixel result channel
interface clpw_pix_if;
    logic                            valid;
    logic                            ready;
    logic                            point_valid;
    logic [clpw_pkg::PIX_X_BITS-1:0] pixel_x;
    logic [clpw_pkg::PIX_Y_BITS-1:0] pixel_y;
    logic                            last_point;
    logic [clpw_pkg::COUNT_BITS-1:0] point_count;

    modport source (
        output valid, point_valid, pixel_x, pixel_y, last_point, point_count,
        input  ready
    );

    modport sink (
        input  valid, point_valid, pixel_x, pixel_y, last_point, point_count,
        output ready
    );
endinterface

### rtl/clpw_setup.sv
// line setup: endpoint ordering, clamping, deltas, major axis and point count
module clpw_setup #(
    parameter int MAX_DIM    = 4096,
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS-1:0]                start_x,
    input  logic signed [COORD_BITS-1:0]                start_y,
    input  logic signed [COORD_BITS-1:0]                end_x,
    input  logic signed [COORD_BITS-1:0]                end_y,
    input  logic [clpw_pkg::CFG_BITS-1:0]               image_width,
    input  logic [clpw_pkg::CFG_BITS-1:0]               image_height,
    output logic [((COORD_BITS-1 > $clog2(MAX_DIM)) ?
                   COORD_BITS-1 : $clog2(MAX_DIM))-1:0] first_x,
    output logic [$clog2(MAX_DIM)-1:0]                  first_y,
    output logic [$clog2(MAX_DIM)-1:0]                  delta_x,
    output logic [$clog2(MAX_DIM)-1:0]                  delta_y,
    output logic                                        step_down,
    output logic                                        x_major,
    output logic [$clog2(MAX_DIM):0]                    point_count
);
    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int XW = (COORD_BITS-1 > DIM_BITS) ? COORD_BITS-1 : DIM_BITS;
    localparam int SW = ((COORD_BITS > DIM_BITS+1) ? COORD_BITS : DIM_BITS+1) + 2;

    logic [31:0]          w_dim;
    logic [31:0]          h_dim;
    logic [31:0]          w_lim;
    logic [31:0]          h_lim;
    logic signed [SW-1:0] w_max;
    logic signed [SW-1:0] h_max;
    logic signed [SW-1:0] sx;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] ex;
    logic signed [SW-1:0] ey;
    logic signed [SW-1:0] ax;
    logic signed [SW-1:0] ay;
    logic signed [SW-1:0] bx;
    logic signed [SW-1:0] by;
    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] dy_raw;
    logic signed [SW-1:0] dy;
    logic signed [SW-1:0] cnt;

    always_comb
    begin
        w_dim = (image_width == '0) ? 32'd1 :
                ((32'(image_width) > MAX_DIM) ? 32'(MAX_DIM) : 32'(image_width));
        h_dim = (image_height == '0) ? 32'd1 :
                ((32'(image_height) > MAX_DIM) ? 32'(MAX_DIM) : 32'(image_height));
        w_lim = w_dim - 32'd1;
        h_lim = h_dim - 32'd1;
        w_max = {{(SW-DIM_BITS){1'b0}}, w_lim[DIM_BITS-1:0]};
        h_max = {{(SW-DIM_BITS){1'b0}}, h_lim[DIM_BITS-1:0]};

        sx = {{(SW-COORD_BITS){start_x[COORD_BITS-1]}}, start_x};
        sy = {{(SW-COORD_BITS){start_y[COORD_BITS-1]}}, start_y};
        ex = {{(SW-COORD_BITS){end_x[COORD_BITS-1]}}, end_x};
        ey = {{(SW-COORD_BITS){end_y[COORD_BITS-1]}}, end_y};

        if (ex < sx)
        begin
            ax = ex;
            ay = ey;
            bx = sx;
            by = sy;
        end
        else
        begin
            ax = sx;
            ay = sy;
            bx = ex;
            by = ey;
        end

        if (ax < 0)
            ax = '0;
        if (bx > w_max)
            bx = w_max;
        if (ay < 0)
            ay = '0;
        else if (ay > h_max)
            ay = h_max;
        if (by < 0)
            by = '0;
        else if (by > h_max)
            by = h_max;

        dx        = bx - ax;
        dy_raw    = by - ay;
        dy        = dy_raw[SW-1] ? -dy_raw : dy_raw;
        step_down = !(ay < by);
        x_major   = dx > dy;
        cnt       = (x_major ? dx : dy) + SW'(1);

        first_x     = ax[XW-1:0];
        first_y     = ay[DIM_BITS-1:0];
        // a left-going clamped line never steps x, so its x delta is held at zero
        delta_x     = (x_major || !dx[SW-1]) ? dx[DIM_BITS-1:0] : '0;
        delta_y     = dy[DIM_BITS-1:0];
        point_count = cnt[DIM_BITS:0];
    end
endmodule

### rtl/clamped_line_pixel_walker.sv
// top level of the clamped line pixel walker
// an accepted word is held in the input register until its result is registered
// throughput: one word per cycle while the pixel sink is ready, one result word per input word
// an input register and a result register decouple the two channels
// reset: asynchronous active-low, clears the line-active flag, the points-left count, pipeline valids and
// loads the image size registers with 640 by 480
module clamped_line_pixel_walker #(
    parameter int MAX_DIM    = 4096,
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [clpw_pkg::CFG_BITS-1:0] cfg_data,
    clpw_seg_if.sink                      seg,
    clpw_pix_if.source                    pixel
);
    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int XW = (COORD_BITS-1 > DIM_BITS) ? COORD_BITS-1 : DIM_BITS;
    localparam int EW = DIM_BITS + 3;

    logic [clpw_pkg::CFG_BITS-1:0] width_reg;
    logic [clpw_pkg::CFG_BITS-1:0] height_reg;

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         s1_func_reg;
    logic signed [COORD_BITS-1:0] s1_sx_reg;
    logic signed [COORD_BITS-1:0] s1_sy_reg;
    logic signed [COORD_BITS-1:0] s1_ex_reg;
    logic signed [COORD_BITS-1:0] s1_ey_reg;

    logic                  line_active_reg;
    logic                  line_active_next;
    logic [XW-1:0]         cur_x_reg;
    logic [XW-1:0]         cur_x_next;
    logic [DIM_BITS-1:0]   cur_y_reg;
    logic [DIM_BITS-1:0]   cur_y_next;
    logic signed [EW-1:0]  err_acc_reg;
    logic signed [EW-1:0]  err_acc_next;
    logic [DIM_BITS-1:0]   delta_x_reg;
    logic [DIM_BITS-1:0]   delta_x_next;
    logic [DIM_BITS-1:0]   delta_y_reg;
    logic [DIM_BITS-1:0]   delta_y_next;
    logic                  step_down_reg;
    logic                  step_down_next;
    logic                  x_major_reg;
    logic                  x_major_next;
    logic [DIM_BITS-1:0]   points_left_reg;
    logic [DIM_BITS-1:0]   points_left_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    clpw_pkg::result_t     out_reg;
    clpw_pkg::result_t     out_next;

    logic                  advance;
    logic                  accept;

    logic [XW-1:0]         su_x;
    logic [DIM_BITS-1:0]   su_y;
    logic [DIM_BITS-1:0]   su_dx;
    logic [DIM_BITS-1:0]   su_dy;
    logic                  su_down;
    logic                  su_xmaj;
    logic [DIM_BITS:0]     su_count;

    clpw_setup #(
        .MAX_DIM    (MAX_DIM),
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x      (s1_sx_reg),
        .start_y      (s1_sy_reg),
        .end_x        (s1_ex_reg),
        .end_y        (s1_ey_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .first_x      (su_x),
        .first_y      (su_y),
        .delta_x      (su_dx),
        .delta_y      (su_dy),
        .step_down    (su_down),
        .x_major      (su_xmaj),
        .point_count  (su_count)
    );

    assign advance   = s1_valid_reg && (!out_valid_reg || pixel.ready);
    assign accept    = seg.valid && seg.ready;
    assign seg.ready = !s1_valid_reg || advance;

    assign pixel.valid       = out_valid_reg;
    assign pixel.point_valid = out_reg.point_valid;
    assign pixel.pixel_x     = out_reg.pixel_x;
    assign pixel.pixel_y     = out_reg.pixel_y;
    assign pixel.last_point  = out_reg.last_point;
    assign pixel.point_count = out_reg.point_count;

    always_comb
    begin
        logic signed [EW-1:0] two_dx;
        logic signed [EW-1:0] two_dy;
        logic signed [EW-1:0] err_sum;
        logic [DIM_BITS-1:0]  y_step;
        logic [DIM_BITS-1:0]  left_dec;
        logic [31:0]          x_wide;
        logic [31:0]          y_wide;
        logic [31:0]          cnt_wide;

        two_dx   = {2'b00, delta_x_reg, 1'b0};
        two_dy   = {2'b00, delta_y_reg, 1'b0};
        y_step   = step_down_reg ? (cur_y_reg - DIM_BITS'(1)) : (cur_y_reg + DIM_BITS'(1));
        left_dec = points_left_reg - DIM_BITS'(1);
        err_sum  = '0;
        x_wide   = '0;
        y_wide   = '0;
        cnt_wide = '0;

        s1_valid_next    = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
        line_active_next = line_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        err_acc_next     = err_acc_reg;
        delta_x_next     = delta_x_reg;
        delta_y_next     = delta_y_reg;
        step_down_next   = step_down_reg;
        x_major_next     = x_major_reg;
        points_left_next = points_left_reg;
        out_valid_next   = advance ? 1'b1 : (pixel.ready ? 1'b0 : out_valid_reg);
        out_next         = out_reg;

        if (advance)
        begin
            if (s1_func_reg == clpw_pkg::FUNC_START)
            begin
                cur_x_next       = su_x;
                cur_y_next       = su_y;
                delta_x_next     = su_dx;
                delta_y_next     = su_dy;
                step_down_next   = su_down;
                x_major_next     = su_xmaj;
                err_acc_next     = su_xmaj ? -{3'b000, su_dx} : -{3'b000, su_dy};
                points_left_next = su_count[DIM_BITS-1:0] - DIM_BITS'(1);
                line_active_next = (su_count[DIM_BITS-1:0] - DIM_BITS'(1)) != '0;
                x_wide   = 32'(su_x);
                y_wide   = 32'(su_y);
                cnt_wide = 32'(su_count);
                out_next.point_valid = 1'b1;
                out_next.pixel_x     = x_wide[clpw_pkg::PIX_X_BITS-1:0];
                out_next.pixel_y     = y_wide[clpw_pkg::PIX_Y_BITS-1:0];
                out_next.last_point  = (su_count[DIM_BITS-1:0] - DIM_BITS'(1)) == '0;
                out_next.point_count = cnt_wide[clpw_pkg::COUNT_BITS-1:0];
            end
            else if (!line_active_reg || points_left_reg == '0)
            begin
                line_active_next = 1'b0;
                out_next         = '0;
            end
            else
            begin
                if (x_major_reg)
                begin
                    cur_x_next = cur_x_reg + XW'(1);
                    err_sum    = err_acc_reg + two_dy;
                    if (!err_sum[EW-1])
                    begin
                        cur_y_next   = y_step;
                        err_acc_next = err_sum - two_dx;
                    end
                    else
                        err_acc_next = err_sum;
                end
                else
                begin
                    cur_y_next = y_step;
                    err_sum    = err_acc_reg + two_dx;
                    if (!err_sum[EW-1])
                    begin
                        cur_x_next   = cur_x_reg + XW'(1);
                        err_acc_next = err_sum - two_dy;
                    end
                    else
                        err_acc_next = err_sum;
                end
                points_left_next = left_dec;
                line_active_next = left_dec != '0;
                x_wide = 32'(cur_x_next);
                y_wide = 32'(cur_y_next);
                out_next.point_valid = 1'b1;
                out_next.pixel_x     = x_wide[clpw_pkg::PIX_X_BITS-1:0];
                out_next.pixel_y     = y_wide[clpw_pkg::PIX_Y_BITS-1:0];
                out_next.last_point  = left_dec == '0;
                out_next.point_count = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg       <= clpw_pkg::WIDTH_RESET;
            height_reg      <= clpw_pkg::HEIGHT_RESET;
            s1_valid_reg    <= 1'b0;
            line_active_reg <= 1'b0;
            points_left_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    clpw_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    clpw_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            s1_valid_reg    <= s1_valid_next;
            line_active_reg <= line_active_next;
            points_left_reg <= points_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= seg.func;
            s1_sx_reg   <= seg.start_x;
            s1_sy_reg   <= seg.start_y;
            s1_ex_reg   <= seg.end_x;
            s1_ey_reg   <= seg.end_y;
        end
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        err_acc_reg   <= err_acc_next;
        delta_x_reg   <= delta_x_next;
        delta_y_reg   <= delta_y_next;
        step_down_reg <= step_down_next;
        x_major_reg   <= x_major_next;
        out_reg       <= out_next;
    end

    a_active_has_points: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> points_left_reg != '0)
        else $error("active line with no points left");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.point_valid) |->
        (out_reg.pixel_x == '0 && out_reg.pixel_y == '0 &&
         !out_reg.last_point && out_reg.point_count == '0))
        else $error("empty result carries nonzero fields");

    a_input_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !pixel.ready) |=>
        (s1_valid_reg && $stable(s1_func_reg) && $stable(s1_sx_reg) && $stable(s1_ex_reg)))
        else $error("input register lost a word under stall");

    a_xmajor_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_func_reg == clpw_pkg::FUNC_STEP && line_active_reg && x_major_reg) |=>
        (cur_x_reg == $past(cur_x_reg) + XW'(1)))
        else $error("x-major step did not advance x");
endmodule

### tb/sv/clpw_checker.sv
// checker for the line pixel walker: predicts each pixel word and compares it with the output
module clpw_checker #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [clpw_pkg::CFG_BITS-1:0] cfg_data,
    clpw_seg_if                           seg_mon,
    clpw_pix_if                           pix_mon,
    output int                            mismatch_count,
    output int                            words_pending
);
    localparam int MAX_PRINTED = 200;

    logic [clpw_pkg::CFG_BITS-1:0] width_reg;
    logic [clpw_pkg::CFG_BITS-1:0] height_reg;

    logic               line_on;
    logic [15:0]        pen_x;
    logic [12:0]        pen_y;
    logic signed [31:0] err_term;
    logic signed [16:0] run_x;
    logic [12:0]        run_y;
    logic               going_down;
    logic               x_leads;
    logic [12:0]        points_to_go;

    clpw_pkg::result_t expected_pixels [$];
    int                pixels_seen;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t pixel word %0d mismatch: %s", $time, pixels_seen, msg);
        mismatch_count++;
    endtask

    function automatic longint usable_dim(input logic [clpw_pkg::CFG_BITS-1:0] r);
        if (r < 1)
            return 1;
        if (r > MAX_DIM)
            return MAX_DIM;
        return longint'(r);
    endfunction

    function automatic clpw_pkg::result_t make_pixel(input longint cnt);
        clpw_pkg::result_t px;
        px.point_valid = 1'b1;
        px.pixel_x     = pen_x[clpw_pkg::PIX_X_BITS-1:0];
        px.pixel_y     = pen_y[clpw_pkg::PIX_Y_BITS-1:0];
        px.last_point  = (points_to_go == 0);
        px.point_count = clpw_pkg::COUNT_BITS'(cnt);
        return px;
    endfunction

    // advances the line state by one command word and returns the pixel word it gives
    function automatic clpw_pkg::result_t walk_line(input logic func,
                                                    input logic signed [15:0] sx,
                                                    input logic signed [15:0] sy,
                                                    input logic signed [15:0] ex,
                                                    input logic signed [15:0] ey);
        longint ax, ay, bx, by, t, w, h, dx, dy, cnt;
        if (func == clpw_pkg::FUNC_START)
        begin
            ax = sx;
            ay = sy;
            bx = ex;
            by = ey;
            w = usable_dim(width_reg);
            h = usable_dim(height_reg);
            if (bx < ax)
            begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            if (ax < 0)
                ax = 0;
            if (bx > w - 1)
                bx = w - 1;
            ay = (ay < 0) ? 0 : ((ay > h - 1) ? h - 1 : ay);
            by = (by < 0) ? 0 : ((by > h - 1) ? h - 1 : by);
            dx = bx - ax;
            dy = (by >= ay) ? by - ay : ay - by;
            going_down = !(ay < by);
            pen_x = 16'(ax);
            pen_y = 13'(ay);
            run_x = 17'(dx);
            run_y = 13'(dy);
            x_leads = dx > dy;
            err_term = 32'(x_leads ? -dx : -dy);
            cnt = x_leads ? dx + 1 : dy + 1;
            points_to_go = 13'(cnt - 1);
            line_on = (points_to_go != 0);
            return make_pixel(cnt);
        end

        if (!line_on || points_to_go == 0)
        begin
            line_on = 1'b0;
            return '0;
        end

        if (x_leads)
        begin
            pen_x = pen_x + 16'd1;
            err_term = err_term + 2 * int'(run_y);
            if (err_term >= 0)
            begin
                pen_y = going_down ? pen_y - 13'd1 : pen_y + 13'd1;
                err_term = err_term - 2 * int'(run_x);
            end
        end
        else
        begin
            pen_y = going_down ? pen_y - 13'd1 : pen_y + 13'd1;
            err_term = err_term + 2 * int'(run_x);
            if (err_term >= 0)
            begin
                pen_x = pen_x + 16'd1;
                err_term = err_term - 2 * int'(run_y);
            end
        end
        points_to_go = points_to_go - 13'd1;
        if (points_to_go == 0)
            line_on = 1'b0;
        return make_pixel(0);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        clpw_pkg::result_t want;
        if (!rst_n)
        begin
            width_reg = clpw_pkg::WIDTH_RESET;
            height_reg = clpw_pkg::HEIGHT_RESET;
            line_on = 1'b0;
            pen_x = '0;
            pen_y = '0;
            err_term = '0;
            run_x = '0;
            run_y = '0;
            going_down = 1'b0;
            x_leads = 1'b0;
            points_to_go = '0;
            expected_pixels.delete();
            pixels_seen = 0;
            mismatch_count = 0;
            words_pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == clpw_pkg::REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end

            if (pix_mon.valid && pix_mon.ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("pixel word with nothing outstanding");
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pix_mon.point_valid !== want.point_valid)
                        report_mismatch($sformatf("point_valid got %0d want %0d",
                                                  pix_mon.point_valid, want.point_valid));
                    if (pix_mon.pixel_x !== want.pixel_x)
                        report_mismatch($sformatf("pixel_x got %0d want %0d",
                                                  pix_mon.pixel_x, want.pixel_x));
                    if (pix_mon.pixel_y !== want.pixel_y)
                        report_mismatch($sformatf("pixel_y got %0d want %0d",
                                                  pix_mon.pixel_y, want.pixel_y));
                    if (pix_mon.last_point !== want.last_point)
                        report_mismatch($sformatf("last_point got %0d want %0d",
                                                  pix_mon.last_point, want.last_point));
                    if (pix_mon.point_count !== want.point_count)
                        report_mismatch($sformatf("point_count got %0d want %0d",
                                                  pix_mon.point_count, want.point_count));
                end
                pixels_seen++;
            end

            if (seg_mon.valid && seg_mon.ready)
                expected_pixels.insert(expected_pixels.size(),
                                       walk_line(seg_mon.func, seg_mon.start_x,
                                                 seg_mon.start_y, seg_mon.end_x,
                                                 seg_mon.end_y));

            words_pending = expected_pixels.size();
        end
    end

endmodule

### tb/sv/tb_top.sv
// testbench top for the line pixel walker: clock, reset, segment stimulus, sink stalls, verdict
module tb_top;
    localparam int PHASES          = 9;
    localparam int WORDS_PER_PHASE = 195;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 2000;

    localparam int PHASE_W [PHASES] = '{4096, 8191, 1, 0, 4096, 37, 3, 640, 0};
    localparam int PHASE_H [PHASES] = '{4096, 8191, 1, 4096, 0, 2, 200, 480, 0};

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic                          cfg_index;
    logic [clpw_pkg::CFG_BITS-1:0] cfg_data;

    int mismatch_count;
    int words_pending;
    int words_sent;
    int send_burst;
    int quiet_cycles;
    bit hold_off_req;

    clpw_seg_if #(.COORD_BITS(16)) seg_ch ();
    clpw_pix_if                    pix_ch ();

    clamped_line_pixel_walker #(
        .MAX_DIM    (4096),
        .COORD_BITS (16)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seg       (seg_ch),
        .pixel     (pix_ch)
    );

    clpw_checker #(
        .MAX_DIM (4096)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .seg_mon        (seg_ch),
        .pix_mon        (pix_ch),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (seg_ch.valid && seg_ch.ready) || (pix_ch.valid && pix_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offers one command word, waits for it to be taken, then maybe idles
    task automatic send_word(input clpw_pkg::func_t f,
                             input logic signed [15:0] sx, input logic signed [15:0] sy,
                             input logic signed [15:0] ex, input logic signed [15:0] ey);
        int r;
        seg_ch.valid   = 1'b1;
        seg_ch.func    = f;
        seg_ch.start_x = sx;
        seg_ch.start_y = sy;
        seg_ch.end_x   = ex;
        seg_ch.end_y   = ey;
        @(posedge clk);
        while (!seg_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
        r = $urandom_range(0, 99);
        if (send_burst > 0)
            send_burst--;
        else if (r < 3)
            send_burst = $urandom_range(30, 150);
        else if (r >= 65)
        begin
            seg_ch.valid = 1'b0;
            repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40))
                @(negedge clk);
        end
    endtask

    // step words carry junk coordinates, which the block ignores
    task automatic send_steps(input int n);
        repeat (n)
            send_word(clpw_pkg::FUNC_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom));
    endtask

    task automatic set_dims(input int w, input int h);
        seg_ch.valid = 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = clpw_pkg::REG_IMAGE_WIDTH;
        cfg_data  = clpw_pkg::CFG_BITS'(w);
        @(negedge clk);
        cfg_index = clpw_pkg::REG_IMAGE_HEIGHT;
        cfg_data  = clpw_pkg::CFG_BITS'(h);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic int dim_clip(input int v);
        return (v < 1) ? 1 : ((v > 4096) ? 4096 : v);
    endfunction

    function automatic logic signed [15:0] border_coord(input int dim);
        case ($urandom_range(0, 6))
            0:       return -16'sd32768;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'(dim - 1);
            4:       return 16'(dim);
            5:       return 16'sd32767;
            default: return 16'sd1;
        endcase
    endfunction

    // one segment start followed by a walk, mostly to its end and a little past it
    task automatic random_line(input int w, input int h);
        int kind, span, n;
        logic signed [15:0] sx, sy, ex, ey;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            sx = 16'(int'($urandom_range(0, w + 19)) - 10);
            sy = 16'(int'($urandom_range(0, h + 19)) - 10);
            ex = 16'(int'(sx) + int'($urandom_range(0, 60)) - 30);
            ey = 16'(int'(sy) + int'($urandom_range(0, 60)) - 30);
            span = (int'(ex) > int'(sx)) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
            n = (int'(ey) > int'(sy)) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
            if (n > span)
                span = n;
            n = ($urandom_range(0, 99) < 85) ? span + int'($urandom_range(0, 2))
                                              : int'($urandom_range(0, span));
        end
        else if (kind < 8)
        begin
            sx = 16'($urandom);
            sy = 16'($urandom);
            ex = 16'($urandom);
            ey = 16'($urandom);
            n = $urandom_range(0, 40);
        end
        else
        begin
            sx = border_coord(w);
            sy = border_coord(h);
            ex = border_coord(w);
            ey = border_coord(h);
            n = $urandom_range(0, 40);
        end
        send_word(clpw_pkg::FUNC_START, sx, sy, ex, ey);
        send_steps(n);
    endtask

    // pixel sink: short stalls, a few long ones, free-running stretches and two long hold-offs
    initial
    begin
        int stall_left, free_left, r;
        stall_left = 0;
        free_left = 0;
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pix_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(negedge clk);
            end
            r = $urandom_range(0, 99);
            if (stall_left > 0)
            begin
                stall_left--;
                pix_ch.ready = 1'b0;
            end
            else
            begin
                pix_ch.ready = 1'b1;
                if (free_left > 0)
                    free_left--;
                else if (r < 3)
                    free_left = $urandom_range(30, 150);
                else if (r < 17)
                    stall_left = $urandom_range(1, 3);
                else if (r < 20)
                    stall_left = $urandom_range(10, 40);
            end
        end
    end

    initial
    begin
        int first, w, h;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = clpw_pkg::REG_IMAGE_WIDTH;
        cfg_data = '0;
        seg_ch.valid = 1'b0;
        seg_ch.func = clpw_pkg::FUNC_START;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.end_x = '0;
        seg_ch.end_y = '0;
        words_sent = 0;
        send_burst = 0;
        hold_off_req = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed lines at the reset image size
        send_steps(1);
        send_word(clpw_pkg::FUNC_START, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_steps(1);
        send_word(clpw_pkg::FUNC_START, 16'sd10, 16'sd20, 16'sd15, 16'sd22);
        send_steps(6);
        send_word(clpw_pkg::FUNC_START, 16'sd5, 16'sd100, 16'sd7, 16'sd90);
        send_steps(2);
        // end clamped left of start while a line is still running
        send_word(clpw_pkg::FUNC_START, 16'sd1000, 16'sd5, 16'sd2000, 16'sd50);
        send_steps(2);
        send_word(clpw_pkg::FUNC_START, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_steps(1);
        send_word(clpw_pkg::FUNC_START, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_word(clpw_pkg::FUNC_START, 16'sd300, -16'sd5, 16'sd300, 16'sd600);
        send_steps(1);
        send_word(clpw_pkg::FUNC_START, 16'sd600, 16'sd10, 16'sd100, 16'sd10);
        send_steps(1);

        for (int p = 0; p < PHASES; p++)
        begin
            w = (p == PHASES - 1) ? int'($urandom_range(1, 4096)) : PHASE_W[p];
            h = (p == PHASES - 1) ? int'($urandom_range(1, 4096)) : PHASE_H[p];
            set_dims(w, h);
            if (p == 0)
            begin
                // full-size diagonal, longest possible line
                send_word(clpw_pkg::FUNC_START, -16'sd32768, -16'sd32768,
                          16'sd32767, 16'sd32767);
                send_steps(3);
            end
            if (p == 1 || p == 7)
                hold_off_req = 1'b1;
            first = words_sent;
            while (words_sent - first < WORDS_PER_PHASE)
                random_line(dim_clip(w), dim_clip(h));
        end

        seg_ch.valid = 1'b0;
        while (words_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/clpw_pkg.sv
rtl/clpw_seg_if.sv
rtl/clpw_pix_if.sv
rtl/clpw_setup.sv
rtl/clamped_line_pixel_walker.sv
tb/sv/clpw_checker.sv
tb/sv/tb_top.sv
